[design/fbpa_pkg.sv]
package fbpa_pkg;

   // field widths
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 16;
   localparam int COUNT_W = 11;
   localparam int SPAN_W  = COUNT_W + SIZE_W;
   localparam int STAT_W  = 3;
   localparam int CSR_IDX_W = 2;

   // defaults for the top level parameters
   localparam int DEFAULT_POOL_DEPTH = 1024;
   localparam int DEFAULT_ADDR_WIDTH = 32;

   // commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STAT_W-1:0] ST_RETURNED = 3'd2;
   localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  pool_base;
      logic [SIZE_W-1:0]  node_size;
      logic [COUNT_W-1:0] node_count;
      logic [SPAN_W-1:0]  span;      // (node_count - 1) * node_size
   } cfg_type;

endpackage

[design/fbpa_stack_ram.sv]
module fbpa_stack_ram #(
   parameter int DEPTH  = fbpa_pkg::DEFAULT_POOL_DEPTH,
   parameter int DATA_W = fbpa_pkg::ADDR_W,
   parameter int IDX_W  = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fbpa_csr.sv]
module fbpa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]         csr_write_data,
   output fbpa_pkg::cfg_type                   cfg,
   output logic                                settling
);

   logic [fbpa_pkg::ADDR_W-1:0]  pool_base_ff, pool_base_in;
   logic [fbpa_pkg::SIZE_W-1:0]  node_size_ff, node_size_in;
   logic [fbpa_pkg::COUNT_W-1:0] node_count_ff, node_count_in;
   logic [fbpa_pkg::SPAN_W-1:0]  span_ff, span_in;
   logic                         settle_ff;
   logic [fbpa_pkg::COUNT_W-1:0] count_less;

   always_comb begin
      pool_base_in  = pool_base_ff;
      node_size_in  = node_size_ff;
      node_count_in = node_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fbpa_pkg::CSR_POOL_BASE: begin
               pool_base_in = csr_write_data;
            end
            fbpa_pkg::CSR_NODE_SIZE: begin
               node_size_in = csr_write_data[fbpa_pkg::SIZE_W-1:0];
            end
            fbpa_pkg::CSR_NODE_COUNT: begin
               node_count_in = csr_write_data[fbpa_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // span to the last node; registered product of the registered count and size
   assign count_less = node_count_ff - fbpa_pkg::COUNT_W'(1);
   assign span_in    = fbpa_pkg::SPAN_W'(count_less) * fbpa_pkg::SPAN_W'(node_size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         node_size_ff  <= '0;
         node_count_ff <= '0;
         span_ff       <= '0;
         settle_ff     <= 1'b0;
      end else begin
         pool_base_ff  <= pool_base_in;
         node_size_ff  <= node_size_in;
         node_count_ff <= node_count_in;
         span_ff       <= span_in;
         settle_ff     <= csr_write_enable;
      end
   end

   assign cfg.pool_base  = pool_base_ff;
   assign cfg.node_size  = node_size_ff;
   assign cfg.node_count = node_count_ff;
   assign cfg.span       = span_ff;
   assign settling       = csr_write_enable | settle_ff;

endmodule

[design/fixed_block_pool_allocator.sv]
// The response word is strobed on rsp_done in the cycle after start is taken.
// Throughput: one command word per cycle while busy is low; the stack RAM is written or read at the
// accept edge and its registered read port feeds the response register stage.
// busy rises only during a register write and the cycle after (span product settles).
// Reset (synchronous, active high) clears config registers, counters and the strobe;
// stack RAM contents and the response address and status are not cleared. The receiver cannot stall responses.
module fixed_block_pool_allocator #(
   parameter int POOL_DEPTH = fbpa_pkg::DEFAULT_POOL_DEPTH,
   parameter int ADDR_WIDTH = fbpa_pkg::DEFAULT_ADDR_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [fbpa_pkg::ADDR_W-1:0]        req_node_address,
   // response channel
   output logic                               rsp_done,
   output logic [fbpa_pkg::ADDR_W-1:0]        rsp_granted_address,
   output logic [fbpa_pkg::STAT_W-1:0]        rsp_status,
   // register write port
   input  logic                               csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]        csr_write_data
);

   // stored entry width: addresses are held modulo 2^ADDR_WIDTH, never above 32 bits
   localparam int EW = (ADDR_WIDTH < fbpa_pkg::ADDR_W) ? ADDR_WIDTH : fbpa_pkg::ADDR_W;
   // stack index and fill count widths
   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);

   fbpa_pkg::cfg_type cfg;
   logic              cfg_settling;

   // free stack state: fill count in flops, entries in RAM
   logic [CW-1:0]                freed_count_ff, freed_count_in;
   logic [fbpa_pkg::COUNT_W-1:0] fresh_used_ff, fresh_used_in;
   logic [fbpa_pkg::ADDR_W-1:0]  fresh_offset_ff, fresh_offset_in;

   // response stage
   logic                         done_ff;
   logic                         pop_ff;
   logic [fbpa_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [fbpa_pkg::STAT_W-1:0]  status_ff, status_in;

   logic                         accept;
   logic                         enabled;
   logic                         have_freed;
   logic                         fresh_left;
   logic                         stack_full;
   logic                         in_range;
   logic [fbpa_pkg::ADDR_W:0]    last_addr;
   logic [fbpa_pkg::ADDR_W-1:0]  fresh_sum;
   logic                         do_pop, do_push, do_fresh;
   logic [CW-1:0]                count_less;
   logic [EW-1:0]                rd_data;

   fbpa_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .settling         (cfg_settling)
   );

   // commands are held off only while a register write settles
   assign busy   = cfg_settling;
   assign accept = start & ~busy;

   assign enabled    = (cfg.node_size != '0) && (cfg.node_count != '0);
   assign have_freed = (freed_count_ff != '0);
   assign fresh_left = (fresh_used_ff < cfg.node_count);
   assign stack_full = (freed_count_ff == CW'(POOL_DEPTH));

   // range test over the unwrapped span: first node to last node inclusive
   assign last_addr = {1'b0, cfg.pool_base} + (fbpa_pkg::ADDR_W + 1)'(cfg.span);
   assign in_range  = (req_node_address >= cfg.pool_base) &&
                      ({1'b0, req_node_address} <= last_addr);

   assign fresh_sum  = cfg.pool_base + fresh_offset_ff;
   assign count_less = freed_count_ff - CW'(1);

   always_comb begin
      do_pop    = 1'b0;
      do_push   = 1'b0;
      do_fresh  = 1'b0;
      status_in = fbpa_pkg::ST_EMPTY;
      addr_in   = '0;
      if (req_cmd == fbpa_pkg::CMD_ALLOC) begin
         if (!enabled) begin
            status_in = fbpa_pkg::ST_EMPTY;
         end else if (have_freed) begin
            // most recently freed node first; data comes from the RAM read
            do_pop    = 1'b1;
            status_in = fbpa_pkg::ST_GRANTED;
         end else if (fresh_left) begin
            do_fresh  = 1'b1;
            status_in = fbpa_pkg::ST_GRANTED;
            addr_in   = fbpa_pkg::ADDR_W'(fresh_sum[EW-1:0]);
         end else begin
            status_in = fbpa_pkg::ST_EMPTY;
         end
      end else begin
         if (!enabled || !in_range) begin
            status_in = fbpa_pkg::ST_OUTSIDE;
         end else if (stack_full) begin
            // full stack: the freed node is dropped
            status_in = fbpa_pkg::ST_OVERFLOW;
         end else begin
            do_push   = 1'b1;
            status_in = fbpa_pkg::ST_RETURNED;
         end
      end
   end

   always_comb begin
      freed_count_in  = freed_count_ff;
      fresh_used_in   = fresh_used_ff;
      fresh_offset_in = fresh_offset_ff;
      if (accept) begin
         if (do_pop) begin
            freed_count_in = count_less;
         end
         if (do_push) begin
            freed_count_in = freed_count_ff + CW'(1);
         end
         if (do_fresh) begin
            fresh_used_in   = fresh_used_ff + fbpa_pkg::COUNT_W'(1);
            fresh_offset_in = fresh_offset_ff + fbpa_pkg::ADDR_W'(cfg.node_size);
         end
      end
   end

   // one word per edge at most, so a push and a later pop never meet in the same cycle
   fbpa_stack_ram #(
      .DEPTH  (POOL_DEPTH),
      .DATA_W (EW),
      .IDX_W  (IW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (accept & do_push),
      .wr_idx  (freed_count_ff[IW-1:0]),
      .wr_data (req_node_address[EW-1:0]),
      .rd_en   (accept & do_pop),
      .rd_idx  (count_less[IW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         freed_count_ff  <= '0;
         fresh_used_ff   <= '0;
         fresh_offset_ff <= '0;
         done_ff         <= 1'b0;
         pop_ff          <= 1'b0;
      end else begin
         freed_count_ff  <= freed_count_in;
         fresh_used_ff   <= fresh_used_in;
         fresh_offset_ff <= fresh_offset_in;
         done_ff         <= accept;
         pop_ff          <= accept & do_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= addr_in;
         status_ff <= status_in;
      end
   end

   // popped grants take the registered RAM word
   assign rsp_done            = done_ff;
   assign rsp_granted_address = pop_ff ? fbpa_pkg::ADDR_W'(rd_data) : addr_ff;
   assign rsp_status          = status_ff;

endmodule
